>>> design/bitset_find_next_prev_macros.svh
// ============================================================================
// bitset_find_next_prev_macros.svh
// Assertion macros shared by the bit set checker.
// ============================================================================
`ifndef BITSET_FIND_NEXT_PREV_MACROS_SVH
`define BITSET_FIND_NEXT_PREV_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFNP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bit set check failed");

// Consequent must hold in the cycle after the antecedent.
`define BFNP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bit set check failed");

`endif

>>> design/bfnp_pkg.sv
// ============================================================================
// bfnp_pkg
// Types, constants and bit search helpers for the bit set block.
// ============================================================================
package bfnp_pkg;

    // Storage word and field widths.
    localparam int WORD_BITS      = 32;
    localparam int LANE_BITS      = 5;
    localparam int OP_W           = 3;
    localparam int IDX_W          = 12;
    localparam int INDEX_BITS_DEF = 12;

    // Request operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_SET       = 3'd0,
        OP_CLEAR     = 3'd1,
        OP_TEST      = 3'd2,
        OP_NEXT      = 3'd3,
        OP_PREV      = 3'd4,
        OP_CLEAR_ALL = 3'd5,
        OP_SET_ALL   = 3'd6
    } t_op;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_WORD,
        S_SCAN,
        S_FETCH,
        S_FINISH
    } t_state;

    // Position of the lowest set bit, found by halving the word five times.
    function automatic logic [LANE_BITS-1:0] first_low(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] v;
        logic [LANE_BITS-1:0] p;
        v = w;
        p = '0;
        if (v[15:0] == '0) begin
            p[4] = 1'b1;
            v    = v >> 16;
        end
        if (v[7:0] == '0) begin
            p[3] = 1'b1;
            v    = v >> 8;
        end
        if (v[3:0] == '0) begin
            p[2] = 1'b1;
            v    = v >> 4;
        end
        if (v[1:0] == '0) begin
            p[1] = 1'b1;
            v    = v >> 2;
        end
        if (v[0] == 1'b0) begin
            p[0] = 1'b1;
        end
        return p;
    endfunction

    // Position of the highest set bit, found by halving the word five times.
    function automatic logic [LANE_BITS-1:0] first_high(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] v;
        logic [LANE_BITS-1:0] p;
        v = w;
        p = '0;
        if (v[31:16] != '0) begin
            p[4] = 1'b1;
            v    = v >> 16;
        end
        if (v[15:8] != '0) begin
            p[3] = 1'b1;
            v    = v >> 8;
        end
        if (v[7:4] != '0) begin
            p[2] = 1'b1;
            v    = v >> 4;
        end
        if (v[3:2] != '0) begin
            p[1] = 1'b1;
            v    = v >> 2;
        end
        if (v[1] != 1'b0) begin
            p[0] = 1'b1;
        end
        return p;
    endfunction

endpackage

>>> design/bitset_find_next_prev.sv
// Flow: set, clear, test, clear all, set all and searches that end in the start word
//   read the word, act on it and then hand the result over; a new request is taken only
//   once the previous result has been handed over, as one item is in work at a time.
// A search that leaves its start word scans the 32-bit chunks of the word summary map
//   (1 to NGROUPS of them) and, on a hit, fetches the found word before it finishes.
//   Reset is synchronous.
// ============================================================================
// bitset_find_next_prev
// Bit set of 2^INDEX_BITS bits in a word memory with a per-word summary map;
// supports set, clear, test, find next set, find previous set, clear and set all.
// ============================================================================
module bitset_find_next_prev #(
    parameter int INDEX_BITS = bfnp_pkg::INDEX_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [bfnp_pkg::OP_W-1:0]    i_operation,
    input  logic [bfnp_pkg::IDX_W-1:0]   i_index,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_hit,
    output logic [bfnp_pkg::IDX_W-1:0]   o_position
);

    localparam int WB      = bfnp_pkg::WORD_BITS;
    localparam int LB      = bfnp_pkg::LANE_BITS;
    localparam int PW      = bfnp_pkg::IDX_W;
    localparam int WA      = (INDEX_BITS > LB) ? INDEX_BITS - LB : 1;
    localparam int NWORDS  = 1 << (INDEX_BITS - LB);
    localparam int GA      = (INDEX_BITS > 2 * LB) ? INDEX_BITS - 2 * LB : 1;
    localparam int NGROUPS = (INDEX_BITS > 2 * LB) ? (1 << (INDEX_BITS - 2 * LB)) : 1;
    localparam int CW      = GA + LB;
    localparam int MAPW    = NGROUPS * WB;
    localparam logic [MAPW-1:0] MAP_FILL  = {MAPW{1'b1}} >> (MAPW - NWORDS);
    localparam logic [WA-1:0]   LAST_WORD = WA'(NWORDS - 1);
    localparam logic [GA-1:0]   LAST_GRP  = GA'(NGROUPS - 1);

    // Bit word memory with a registered read.
    logic [WB-1:0] r_mem [NWORDS];
    logic [WB-1:0] r_rdata;

    bfnp_pkg::t_state r_state, n_state;
    logic [bfnp_pkg::OP_W-1:0] r_op, n_op;
    logic [WA-1:0]     r_waddr, n_waddr;
    logic [LB-1:0]     r_bit, n_bit;
    logic [WA-1:0]     r_rd_addr, n_rd_addr;
    logic [CW-1:0]     r_cur, n_cur;
    logic [NWORDS-1:0] r_wvalid, n_wvalid;
    logic [MAPW-1:0]   r_map, n_map;
    logic              r_fill, n_fill;
    logic              r_res_hit, n_res_hit;
    logic [PW-1:0]     r_res_pos, n_res_pos;
    logic              r_out_valid, n_out_valid;
    logic              r_out_hit, n_out_hit;
    logic [PW-1:0]     r_out_pos, n_out_pos;

    logic              rd_en;
    logic [WA-1:0]     rd_addr;
    logic              wr_en;
    logic [WB-1:0]     wr_data;

    logic [INDEX_BITS-1:0] in_idx;
    logic                  in_xfer;
    logic [WB-1:0]         word_eff;
    logic [WB-1:0]         masked;
    logic [WB-1:0]         chunk;
    logic [GA-1:0]         grp;
    logic [LB-1:0]         lane;
    logic [PW-1:0]         pos_idx;

    // Bit position from a word address and a lane, cut to the position field.
    function automatic logic [PW-1:0] f_pos(input logic [WA-1:0] w, input logic [LB-1:0] b);
        logic [INDEX_BITS+LB-1:0] full;
        full = ((INDEX_BITS + LB)'(w) << LB) | (INDEX_BITS + LB)'(b);
        return PW'(full);
    endfunction

    assign in_idx   = INDEX_BITS'(i_index);
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign word_eff = r_wvalid[r_rd_addr] ? r_rdata : {WB{r_fill}};
    assign grp      = r_cur[CW-1:LB];
    assign lane     = r_cur[LB-1:0];
    assign chunk    = r_map[{grp, {LB{1'b0}}} +: WB];
    assign pos_idx  = f_pos(r_waddr, r_bit);

    // Memory port: registered read, one write.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_waddr] <= wr_data;
        end
    end

    // Control state and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfnp_pkg::S_IDLE;
            r_wvalid    <= '0;
            r_map       <= '0;
            r_fill      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wvalid    <= n_wvalid;
            r_map       <= n_map;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_op      <= n_op;
        r_waddr   <= n_waddr;
        r_bit     <= n_bit;
        r_rd_addr <= n_rd_addr;
        r_cur     <= n_cur;
        r_res_hit <= n_res_hit;
        r_res_pos <= n_res_pos;
        r_out_hit <= n_out_hit;
        r_out_pos <= n_out_pos;
    end

    // Next state, memory accesses and results.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_waddr     = r_waddr;
        n_bit       = r_bit;
        n_rd_addr   = r_rd_addr;
        n_cur       = r_cur;
        n_wvalid    = r_wvalid;
        n_map       = r_map;
        n_fill      = r_fill;
        n_res_hit   = r_res_hit;
        n_res_pos   = r_res_pos;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_hit   = r_out_hit;
        n_out_pos   = r_out_pos;
        rd_en       = 1'b0;
        rd_addr     = r_rd_addr;
        wr_en       = 1'b0;
        wr_data     = word_eff;
        masked      = '0;

        unique case (r_state)
            bfnp_pkg::S_IDLE: begin
                // Take a request and read its word.
                if (in_xfer) begin
                    n_op      = i_operation;
                    n_waddr   = WA'(in_idx >> LB);
                    n_bit     = in_idx[LB-1:0];
                    n_rd_addr = WA'(in_idx >> LB);
                    rd_en     = 1'b1;
                    rd_addr   = WA'(in_idx >> LB);
                    n_state   = bfnp_pkg::S_WORD;
                end
            end

            bfnp_pkg::S_WORD: begin
                // Act on the word that holds the index.
                n_res_hit = 1'b1;
                n_res_pos = pos_idx;
                n_state   = bfnp_pkg::S_FINISH;
                unique case (r_op) inside
                    bfnp_pkg::OP_SET, bfnp_pkg::OP_CLEAR: begin
                        wr_en = 1'b1;
                        if (r_op == bfnp_pkg::OP_SET) begin
                            wr_data = word_eff | (WB'(1) << r_bit);
                        end else begin
                            wr_data = word_eff & ~(WB'(1) << r_bit);
                        end
                        n_wvalid[r_waddr]  = 1'b1;
                        n_map[CW'(r_waddr)] = (wr_data != '0);
                    end
                    bfnp_pkg::OP_TEST: begin
                        n_res_hit = word_eff[r_bit];
                    end
                    bfnp_pkg::OP_NEXT: begin
                        masked = word_eff & ({WB{1'b1}} << r_bit);
                        if (masked != '0) begin
                            n_res_pos = f_pos(r_waddr, bfnp_pkg::first_low(masked));
                        end else if (r_waddr == LAST_WORD) begin
                            n_res_hit = 1'b0;
                        end else begin
                            n_cur   = CW'(r_waddr) + CW'(1);
                            n_state = bfnp_pkg::S_SCAN;
                        end
                    end
                    bfnp_pkg::OP_PREV: begin
                        masked = word_eff & ({WB{1'b1}} >> (LB'(WB - 1) - r_bit));
                        if (masked != '0) begin
                            n_res_pos = f_pos(r_waddr, bfnp_pkg::first_high(masked));
                        end else if (r_waddr == '0) begin
                            n_res_hit = 1'b0;
                        end else begin
                            n_cur   = CW'(r_waddr) - CW'(1);
                            n_state = bfnp_pkg::S_SCAN;
                        end
                    end
                    bfnp_pkg::OP_CLEAR_ALL: begin
                        n_wvalid = '0;
                        n_fill   = 1'b0;
                        n_map    = '0;
                    end
                    bfnp_pkg::OP_SET_ALL: begin
                        n_wvalid = '0;
                        n_fill   = 1'b1;
                        n_map    = MAP_FILL;
                    end
                    default: begin
                        n_res_hit = 1'b0;
                    end
                endcase
            end

            bfnp_pkg::S_SCAN: begin
                // Walk the summary map one chunk per cycle.
                if (r_op == bfnp_pkg::OP_NEXT) begin
                    masked = chunk & ({WB{1'b1}} << lane);
                    if (masked != '0) begin
                        rd_en     = 1'b1;
                        rd_addr   = WA'({grp, bfnp_pkg::first_low(masked)});
                        n_rd_addr = rd_addr;
                        n_state   = bfnp_pkg::S_FETCH;
                    end else if (grp == LAST_GRP) begin
                        n_res_hit = 1'b0;
                        n_state   = bfnp_pkg::S_FINISH;
                    end else begin
                        n_cur = {grp + GA'(1), {LB{1'b0}}};
                    end
                end else begin
                    masked = chunk & ({WB{1'b1}} >> (LB'(WB - 1) - lane));
                    if (masked != '0) begin
                        rd_en     = 1'b1;
                        rd_addr   = WA'({grp, bfnp_pkg::first_high(masked)});
                        n_rd_addr = rd_addr;
                        n_state   = bfnp_pkg::S_FETCH;
                    end else if (grp == '0) begin
                        n_res_hit = 1'b0;
                        n_state   = bfnp_pkg::S_FINISH;
                    end else begin
                        n_cur = {grp - GA'(1), {LB{1'b1}}};
                    end
                end
            end

            bfnp_pkg::S_FETCH: begin
                // The fetched word is known to hold a set bit.
                n_res_hit = 1'b1;
                if (r_op == bfnp_pkg::OP_NEXT) begin
                    n_res_pos = f_pos(r_rd_addr, bfnp_pkg::first_low(word_eff));
                end else begin
                    n_res_pos = f_pos(r_rd_addr, bfnp_pkg::first_high(word_eff));
                end
                n_state = bfnp_pkg::S_FINISH;
            end

            bfnp_pkg::S_FINISH: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_res_hit;
                    n_out_pos   = r_res_pos;
                    n_state     = bfnp_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bfnp_pkg::S_IDLE;
            end
        endcase
    end

    // Ports.
    assign o_in_stall  = (r_state != bfnp_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_position  = r_out_pos;

endmodule

>>> design/bfnp_checker.sv
// ============================================================================
// bfnp_checker
// Port-level checks on the bit set block, attached by bind.
// ============================================================================
`include "bitset_find_next_prev_macros.svh"

module bfnp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic [bfnp_pkg::OP_W-1:0]  i_operation,
    input logic [bfnp_pkg::IDX_W-1:0] i_index,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic                       o_hit,
    input logic [bfnp_pkg::IDX_W-1:0] o_position
);

    // A result is offered but held back by the receiver.
    logic res_held;
    assign res_held = o_out_valid && i_out_stall;

    // A stalled result stays offered.
    `BFNP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // A stalled result keeps its payload.
    `BFNP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, res_held, $stable(o_hit) && $stable(o_position))

    // Only one request is in work: a transfer closes the input until its result is built.
    `BFNP_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // A new result appears only while a request was in work.
    `BFNP_ASSERT_NOW(a_result_source, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind bitset_find_next_prev bfnp_checker u_bfnp_checker (.*);
